// ===== hdl/pctd_pkg.sv =====
package pctd_pkg;

   // Default width of the tested value
   localparam int VALUE_WIDTH_DEFAULT = 32;

   // Width of the batch prime count
   localparam int COUNT_WIDTH = 32;

   // Depth of the queue between the front and back parts
   localparam int QUEUE_DEPTH = 2;

   // Classification that travels with each queued value
   typedef struct packed {
      logic candidate;   // non-negative and at least two
      logic last;        // final beat of the batch
   } item_ctrl_type;

endpackage

// ===== hdl/pctd_front.sv =====
module pctd_front #(
   parameter int VALUE_WIDTH = pctd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [VALUE_WIDTH-1:0]  req_number,
   input  logic                    req_last_in_batch,
   output logic                    q_valid,
   input  logic                    q_pop,
   output logic [VALUE_WIDTH-1:0]  q_value,
   output pctd_pkg::item_ctrl_type q_ctrl
);

   localparam int DEPTH = pctd_pkg::QUEUE_DEPTH;
   localparam int PW    = $clog2(DEPTH);
   localparam int FW    = $clog2(DEPTH + 1);

   logic [VALUE_WIDTH-1:0]  value_ff [DEPTH];
   pctd_pkg::item_ctrl_type ctrl_ff  [DEPTH];
   logic [PW-1:0]           wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]           rd_ptr_ff, rd_ptr_in;
   logic [FW-1:0]           fill_ff, fill_in;
   logic                    push;
   logic                    pop;
   pctd_pkg::item_ctrl_type ctrl_new;

   // Classify the incoming beat: negative, zero and one are never prime
   always_comb begin
      ctrl_new.candidate = !req_number[VALUE_WIDTH-1] && (req_number[VALUE_WIDTH-1:1] != '0);
      ctrl_new.last      = req_last_in_batch;
   end

   assign req_stall = (fill_ff == FW'(DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (fill_ff != '0);
   assign pop       = q_pop && q_valid;
   assign q_value   = value_ff[rd_ptr_ff];
   assign q_ctrl    = ctrl_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (push && !pop) begin
         fill_in = fill_ff + FW'(1);
      end else if (!push && pop) begin
         fill_in = fill_ff - FW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   // Store the accepted beat
   always_ff @(posedge clock) begin
      if (push) begin
         value_ff[wr_ptr_ff] <= req_number;
         ctrl_ff[wr_ptr_ff]  <= ctrl_new;
      end
   end

endmodule

// ===== hdl/pctd_back.sv =====
module pctd_back #(
   parameter int VALUE_WIDTH = pctd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             q_valid,
   output logic                             q_pop,
   input  logic [VALUE_WIDTH-1:0]           q_value,
   input  pctd_pkg::item_ctrl_type          q_ctrl,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pctd_pkg::COUNT_WIDTH-1:0] rsp_prime_count
);

   localparam int W     = VALUE_WIDTH;
   localparam int CW    = pctd_pkg::COUNT_WIDTH;
   localparam int JW    = (W + 1) / 2 + 2;   // trial divisor
   localparam int SQW   = W + 2;             // square of trial divisor
   localparam int STEPS = (W + 1) / 2;       // two remainder bits per cycle
   localparam int DPW   = 2 * STEPS;
   localparam int SW    = $clog2(STEPS);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_CHECK  = 4'b0010,
      ST_DIVIDE = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type               state_ff, state_in;
   logic [W-1:0]            n_ff, n_in;
   pctd_pkg::item_ctrl_type ctrl_ff, ctrl_in;
   logic [JW-1:0]           j_ff, j_in;
   logic [SQW-1:0]          sq_ff, sq_in;
   logic [JW-1:0]           rem_ff, rem_in;
   logic [DPW-1:0]          dv_ff, dv_in;
   logic [SW-1:0]           step_ff, step_in;
   logic                    prime_ff, prime_in;
   logic [CW-1:0]           count_ff, count_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]           rsp_count_ff, rsp_count_in;
   logic [JW:0]             rem_a;
   logic [JW:0]             rem_b;
   logic [JW-1:0]           rem_next;
   logic [CW-1:0]           count_next;
   logic                    out_free;

   // Two restoring remainder steps per cycle
   always_comb begin
      rem_a = {rem_ff, dv_ff[DPW-1]};
      if (rem_a >= {1'b0, j_ff}) begin
         rem_a = rem_a - {1'b0, j_ff};
      end
      rem_b = {rem_a[JW-1:0], dv_ff[DPW-2]};
      if (rem_b >= {1'b0, j_ff}) begin
         rem_b = rem_b - {1'b0, j_ff};
      end
      rem_next = rem_b[JW-1:0];
   end

   assign count_next = (prime_ff && (count_ff != '1)) ? count_ff + CW'(1) : count_ff;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;

   // Sequence one number through the odd trial divisors
   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      ctrl_in      = ctrl_ff;
      j_in         = j_ff;
      sq_in        = sq_ff;
      rem_in       = rem_ff;
      dv_in        = dv_ff;
      step_in      = step_ff;
      prime_in     = prime_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_count_in = rsp_count_ff;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               n_in    = q_value;
               ctrl_in = q_ctrl;
               j_in    = JW'(3);
               sq_in   = SQW'(9);
               if (!q_ctrl.candidate) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else if ((q_value == W'(2)) || (q_value == W'(3))) begin
                  prime_in = 1'b1;
                  state_in = ST_FINISH;
               end else if (!q_value[0]) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_CHECK;
               end
            end
         end
         ST_CHECK: begin
            // Stop once the divisor passes the square root
            if (sq_ff > SQW'(n_ff)) begin
               prime_in = 1'b1;
               state_in = ST_FINISH;
            end else begin
               rem_in   = '0;
               dv_in    = DPW'(n_ff);
               step_in  = '0;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            rem_in  = rem_next;
            dv_in   = dv_ff << 2;
            step_in = step_ff + SW'(1);
            if (step_ff == SW'(STEPS - 1)) begin
               if (rem_next == '0) begin
                  prime_in = 1'b0;
                  state_in = ST_FINISH;
               end else begin
                  // (j+2)^2 = j^2 + 4j + 4
                  sq_in    = sq_ff + SQW'({j_ff, 2'b00}) + SQW'(4);
                  j_in     = j_ff + JW'(2);
                  state_in = ST_CHECK;
               end
            end
         end
         ST_FINISH: begin
            if (!ctrl_ff.last) begin
               count_in = count_next;
               state_in = ST_IDLE;
            end else if (out_free) begin
               // Hand the batch count to the output register and clear
               rsp_valid_in = 1'b1;
               rsp_count_in = count_next;
               count_in     = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff         <= n_in;
      ctrl_ff      <= ctrl_in;
      j_ff         <= j_in;
      sq_ff        <= sq_in;
      rem_ff       <= rem_in;
      dv_ff        <= dv_in;
      step_ff      <= step_in;
      prime_ff     <= prime_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_count = rsp_count_ff;

endmodule

// ===== hdl/prime_count_trial_division.sv =====
// Counts primes in batches of signed numbers by trial division. Each request
// beat carries one number; a beat marked last_in_batch produces one response
// beat with the number of primes in the batch (saturating), then the count
// restarts. The front part classifies numbers and queues up to two of them,
// so requests are still taken while the back part works, until the queue is
// full. The back part rejects numbers below two and even numbers, and accepts
// two and three, without division, then tries odd divisors 3, 5, 7, ... while
// the divisor's square does not exceed the number. Each divisor passes through
// the check state and the remainder unit, which retires two bits per cycle;
// a large 32-bit prime needs up to about 23170 divisors.
module prime_count_trial_division #(
   parameter int VALUE_WIDTH = pctd_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [VALUE_WIDTH-1:0]           req_number,
   input  logic                             req_last_in_batch,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [pctd_pkg::COUNT_WIDTH-1:0] rsp_prime_count
);

   logic                    q_valid;
   logic                    q_pop;
   logic [VALUE_WIDTH-1:0]  q_value;
   pctd_pkg::item_ctrl_type q_ctrl;

   // Accept, classify and queue
   pctd_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_number        (req_number),
      .req_last_in_batch (req_last_in_batch),
      .q_valid           (q_valid),
      .q_pop             (q_pop),
      .q_value           (q_value),
      .q_ctrl            (q_ctrl)
   );

   // Trial division, batch count and response register
   pctd_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_valid         (q_valid),
      .q_pop           (q_pop),
      .q_value         (q_value),
      .q_ctrl          (q_ctrl),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_prime_count (rsp_prime_count)
   );

endmodule

// ===== tb/prime_count_trial_division_tb.sv =====
`timescale 1ns / 100ps

module prime_count_trial_division_tb;

   localparam int VW = pctd_pkg::VALUE_WIDTH_DEFAULT;
   localparam int CW = pctd_pkg::COUNT_WIDTH;
   localparam int RANDOM_ITEMS = 70;
   localparam int QUIET_TAIL = 20;
   localparam int LONG_HOLD = 400;
   localparam int BURST_ITEMS = 10;
   localparam int DRAIN_CYCLES = 200;
   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [CW-1:0] COUNT_MAX = '1;

   // One row of the directed table; typed rows carry a hand-written count
   typedef struct packed {
      logic [VW-1:0] number;
      logic          last;
      logic          typed;
      logic [CW-1:0] count;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 22;
   localparam stim_row_type DIRECTED [DIRECTED_ROWS] = '{
      '{32'h0000_0000, 1'b1, 1'b1, 32'd0},   // empty count right after reset
      '{32'h8000_0000, 1'b0, 1'b0, 32'd0},   // most negative
      '{32'hFFFF_FFFF, 1'b0, 1'b0, 32'd0},   // minus one
      '{32'h0000_0001, 1'b0, 1'b0, 32'd0},
      '{32'h0000_0002, 1'b1, 1'b1, 32'd1},   // smallest prime closes the batch
      '{32'h7FFF_FFFF, 1'b1, 1'b0, 32'd0},   // largest positive, long search
      '{32'h0000_0003, 1'b0, 1'b0, 32'd0},
      '{32'h0000_0004, 1'b0, 1'b0, 32'd0},
      '{32'h0000_0009, 1'b0, 1'b0, 32'd0},   // odd squares hit the j*j bound
      '{32'h0000_0019, 1'b0, 1'b0, 32'd0},
      '{32'h0000_0031, 1'b1, 1'b1, 32'd1},
      '{32'h0000_0005, 1'b0, 1'b0, 32'd0},
      '{32'h0000_0007, 1'b0, 1'b0, 32'd0},
      '{32'h0000_000B, 1'b0, 1'b0, 32'd0},
      '{32'h0000_000D, 1'b1, 1'b0, 32'd0},
      '{32'h7FFF_FFFE, 1'b0, 1'b0, 32'd0},
      '{32'h7FFF_FFFD, 1'b0, 1'b0, 32'd0},
      '{32'h0000_FFF1, 1'b0, 1'b0, 32'd0},
      '{32'h0000_FFFF, 1'b1, 1'b0, 32'd0},
      '{32'hFFFF_FFFE, 1'b1, 1'b1, 32'd0},   // single negative batch
      '{32'h5555_5555, 1'b0, 1'b0, 32'd0},
      '{32'h0000_0001, 1'b1, 1'b0, 32'd0}
   };

   logic          clock = 1'b0;
   logic          reset = 1'b1;
   logic          req_valid = 1'b0;
   logic          req_stall;
   logic [VW-1:0] req_number = '0;
   logic          req_last_in_batch = 1'b0;
   logic          rsp_valid;
   logic          rsp_stall = 1'b0;
   logic [CW-1:0] rsp_prime_count;

   // Hand-written count that travels with the beat on the request side
   logic          beat_typed = 1'b0;
   logic [CW-1:0] beat_typed_count = '0;

   logic [CW-1:0] expected_counts [$];
   logic [CW-1:0] batch_primes = '0;
   int            errors = 0;
   int            cycle_count = 0;
   bit            quiet = 1'b0;
   bit            hold_request = 1'b0;

   prime_count_trial_division #(.VALUE_WIDTH(VW)) dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_number        (req_number),
      .req_last_in_batch (req_last_in_batch),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_prime_count   (rsp_prime_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Trial division on the value read as unsigned, stop at the first divisor
   function automatic bit number_is_prime(input logic [VW-1:0] value);
      longint unsigned n;
      longint unsigned j;
      n = 64'(value);
      if (n < 2)
         return 1'b0;
      for (j = 2; j <= n / j; j++)
         if (n % j == 0)
            return 1'b0;
      return 1'b1;
   endfunction

   // Mostly cheap values; large ones are negative, even or multiples of three
   function automatic logic [VW-1:0] random_number();
      logic [VW-1:0] n;
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: n = $urandom_range(0, 2000);
         5:             n = $urandom_range(0, 65535);
         6, 7:          n = $urandom | 32'h8000_0000;
         8:             n = $urandom & 32'h7FFF_FFFE;
         default:       n = 3 * $urandom_range(1, 715827882);
      endcase
      return n;
   endfunction

   // Offer one beat, hold it until accepted, then maybe idle for a burst
   task automatic offer_beat(input logic [VW-1:0] n, input logic l, input logic t,
                             input logic [CW-1:0] c);
      int gap;
      req_valid         <= 1'b1;
      req_number        <= n;
      req_last_in_batch <= l;
      beat_typed        <= t;
      beat_typed_count  <= c;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 7);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering until every expected count has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_counts.size() != 0)
         @(posedge clock);
   endtask

   // Predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      logic [CW-1:0] want;
      if (reset) begin
         batch_primes = '0;
      end else begin
         if (req_valid && !req_stall) begin
            if (!req_number[VW-1] && number_is_prime(req_number) &&
                batch_primes != COUNT_MAX)
               batch_primes = batch_primes + CW'(1);
            if (req_last_in_batch) begin
               expected_counts.push_back(beat_typed ? beat_typed_count : batch_primes);
               batch_primes = '0;
            end
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_counts.size() == 0) begin
               $display("%0t: unexpected response, expected none, actual prime_count %0d",
                        $time, rsp_prime_count);
               errors++;
            end else begin
               want = expected_counts.pop_front();
               if (rsp_prime_count !== want) begin
                  $display("%0t: prime_count mismatch, expected %0d, actual %0d",
                           $time, want, rsp_prime_count);
                  errors++;
               end
            end
         end
      end
   end

   // Receiver: random stall bursts, one long hold on request, none when quiet
   initial begin
      int k;
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            k = $urandom_range(1, 7);
            rsp_stall <= 1'b1;
            repeat (k) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Bound the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("prime_count_trial_division_tb: FAIL");
         $finish;
      end
   end

   // Sender: directed table, a burst against a long hold, then random batches
   initial begin
      int sent;
      int batch_len;
      int k;
      logic last;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++)
         offer_beat(DIRECTED[i].number, DIRECTED[i].last, DIRECTED[i].typed,
                    DIRECTED[i].count);
      pause_until_drained();

      // Fill the block while the receiver holds off
      hold_request = 1'b1;
      repeat (BURST_ITEMS) offer_beat($urandom_range(0, 200), 1'b1, 1'b0, '0);

      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         batch_len = $urandom_range(1, 8);
         for (k = 0; k < batch_len && sent < RANDOM_ITEMS; k++) begin
            if (sent == RANDOM_ITEMS / 2)
               pause_until_drained();
            if (sent >= RANDOM_ITEMS - QUIET_TAIL)
               quiet = 1'b1;
            last = (k == batch_len - 1) || (sent == RANDOM_ITEMS - 1);
            offer_beat(random_number(), last, 1'b0, '0);
            sent++;
         end
      end

      // Drain, then watch for stray responses
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && expected_counts.size() == 0)
         $display("prime_count_trial_division_tb: PASS");
      else
         $display("prime_count_trial_division_tb: FAIL");
      $finish;
   end

endmodule
